[sv/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        RS_A,
        RS_B,
        RS_R
    } t_red_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_START,
        S_GCD,
        S_DIV,
        S_STORE,
        S_DZ,
        S_MUL,
        S_COMB,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       red_start;
        logic       gcd_step;
        logic       div_start;
        logic       div_step;
        logic       red_store;
        t_red_sel   sel;
        logic       mul_step;
        logic [1:0] mul_idx;
        logic       comb;
        logic       st_we;
        logic [1:0] st_code;
        logic       out_we;
    } t_dp_cmd;

    typedef struct packed {
        logic zero_den;
        logic div_zero;
        logic gcd_done;
        logic div_done;
        logic red_ovf;
        logic comb_ovf;
    } t_dp_stat;

endpackage

`default_nettype wire

[sv/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: operand reduction, products, combination, result reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire logic     i_out_free,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    t_state     r_state, n_state;
    t_red_sel   r_sel, n_sel;
    logic [1:0] r_midx, n_midx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= RS_A;
            r_midx  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_midx  <= n_midx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_midx  = r_midx;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CHECK;
            S_CHECK: begin
                n_state = i_stat.zero_den ? S_OUT : S_START;
                n_sel   = RS_A;
            end
            S_START: n_state = S_GCD;
            S_GCD:   if (i_stat.gcd_done) n_state = S_DIV;
            S_DIV:   if (i_stat.div_done) n_state = S_STORE;
            S_STORE: begin
                if (i_stat.red_ovf) begin
                    n_state = S_OUT;
                end else begin
                    unique case (r_sel)
                        RS_A: begin
                            n_sel   = RS_B;
                            n_state = S_START;
                        end
                        RS_B:    n_state = S_DZ;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_DZ: begin
                n_midx  = 2'd0;
                n_state = i_stat.div_zero ? S_OUT : S_MUL;
            end
            S_MUL: begin
                n_midx = r_midx + 2'd1;
                if (r_midx == 2'd3) n_state = S_COMB;
            end
            S_COMB: begin
                n_sel   = RS_R;
                n_state = i_stat.comb_ovf ? S_OUT : S_START;
            end
            S_OUT:   if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_in_ready = 1'b0;
        o_cmd.mul_idx = r_midx;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.st_we   = i_stat.zero_den;
                o_cmd.st_code = ST_ZERO_DEN;
            end
            S_START: o_cmd.red_start = 1'b1;
            S_GCD: begin
                o_cmd.div_start = i_stat.gcd_done;
                o_cmd.gcd_step  = !i_stat.gcd_done;
            end
            S_DIV:   o_cmd.div_step = !i_stat.div_done;
            S_STORE: begin
                if (i_stat.red_ovf) begin
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = ST_OVERFLOW;
                end else begin
                    o_cmd.red_store = 1'b1;
                    o_cmd.st_we     = (r_sel == RS_R);
                    o_cmd.st_code   = ST_OK;
                end
            end
            S_DZ: begin
                o_cmd.st_we   = i_stat.div_zero;
                o_cmd.st_code = ST_DIV_ZERO;
            end
            S_MUL:  o_cmd.mul_step = 1'b1;
            S_COMB: begin
                o_cmd.st_we   = i_stat.comb_ovf;
                o_cmd.st_code = ST_OVERFLOW;
                o_cmd.comb    = !i_stat.comb_ovf;
            end
            S_OUT:   o_cmd.out_we = i_out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[sv/rau_dp.sv]
// ----------------------------------------------------------------------------
// rau_dp
// Operand registers, binary gcd, twin restoring dividers, shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_dp
    import rau_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic          i_clk,
    input  wire t_dp_cmd       i_cmd,
    output t_dp_stat           o_stat,
    input  wire logic [1:0]    i_mode,
    input  wire logic [31:0]   i_a_num,
    input  wire logic [31:0]   i_a_den,
    input  wire logic [31:0]   i_b_num,
    input  wire logic [31:0]   i_b_den,
    output logic signed [31:0] o_res_num,
    output logic [30:0]        o_res_den,
    output logic [1:0]         o_status
);

    localparam int KW = $clog2(W);
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0]   MAXV  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   MINM  = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W-1:0] MAXV2 = {{(W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [2*W-1:0] MINM2 = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

    logic [1:0]         r_mode;
    logic [W-1:0]       r_an, r_ad, r_bn, r_bd, r_rn, r_rd;
    logic               r_rs;
    logic [W-1:0]       r_u, r_v, r_g, r_qn, r_qd, r_mn, r_md;
    logic [KW-1:0]      r_k;
    logic [CW-1:0]      r_cnt;
    logic [2*W-1:0]     r_p [4];
    logic [1:0]         r_st;
    logic [W-1:0]       r_onum;
    logic [W-2:0]       r_oden;
    logic [1:0]         r_ost;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic fit_sm(input logic s, input logic [2*W-1:0] m);
        return s ? (m <= MINM2) : (m <= MAXV2);
    endfunction

    function automatic logic [W-1:0] sval(input logic s, input logic [2*W-1:0] m);
        return s ? (~m[W-1:0] + 1'b1) : m[W-1:0];
    endfunction

    function automatic logic [2*W-1:0] dstep(input logic [W-1:0] rm,
                                             input logic [W-1:0] q,
                                             input logic [W-1:0] dv);
        logic [W:0] t;
        t = {rm, q[W-1]};
        if (t >= {1'b0, dv}) begin
            t = t - {1'b0, dv};
            return {t[W-1:0], q[W-2:0], 1'b1};
        end
        return {t[W-1:0], q[W-2:0], 1'b0};
    endfunction

    logic [W-1:0]   sn, sd, g, nn, mul_x, mul_y, pv, qv, rn_c, rd_c;
    logic [2*W-1:0] dn, dd;
    logic           sa, sb, c_ovf;
    logic [W:0]     sum;

    always_comb begin
        unique case (i_cmd.sel)
            RS_A: begin
                sn = r_an;
                sd = r_ad;
            end
            RS_B: begin
                sn = r_bn;
                sd = r_bd;
            end
            default: begin
                sn = r_rn;
                sd = r_rd;
            end
        endcase
    end

    assign g  = (r_u | r_v) << r_k;
    assign dn = dstep(r_mn, r_qn, r_g);
    assign dd = dstep(r_md, r_qd, r_g);
    assign nn = r_rs ? (~r_qn + 1'b1) : r_qn;

    always_comb begin
        case (i_cmd.mul_idx)
            2'd0: begin
                mul_x = mag(r_an);
                mul_y = r_bd;
            end
            2'd1: begin
                mul_x = r_ad;
                mul_y = mag(r_bn);
            end
            2'd2: begin
                mul_x = mag(r_an);
                mul_y = mag(r_bn);
            end
            default: begin
                mul_x = r_ad;
                mul_y = r_bd;
            end
        endcase
    end

    assign sa = r_an[W-1];
    assign sb = r_bn[W-1];
    assign pv = sval(sa, r_p[0]);
    assign qv = sval(sb, r_p[1]);
    assign sum = (r_mode == MODE_ADD) ? ({pv[W-1], pv} + {qv[W-1], qv})
                                      : ({pv[W-1], pv} - {qv[W-1], qv});

    always_comb begin
        case (r_mode)
            MODE_ADD, MODE_SUB: begin
                c_ovf = !fit_sm(sa, r_p[0]) || !fit_sm(sb, r_p[1]) ||
                        !fit_sm(1'b0, r_p[3]) || (sum[W] != sum[W-1]);
                rn_c  = sum[W-1:0];
                rd_c  = r_p[3][W-1:0];
            end
            MODE_MUL: begin
                c_ovf = !fit_sm(sa ^ sb, r_p[2]) || !fit_sm(1'b0, r_p[3]);
                rn_c  = sval(sa ^ sb, r_p[2]);
                rd_c  = r_p[3][W-1:0];
            end
            default: begin
                c_ovf = !fit_sm(sa, r_p[0]) || !fit_sm(sb, r_p[1]);
                rn_c  = pv;
                rd_c  = qv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_an   <= i_a_num[W-1:0];
            r_ad   <= i_a_den[W-1:0];
            r_bn   <= i_b_num[W-1:0];
            r_bd   <= i_b_den[W-1:0];
        end
        if (i_cmd.red_start) begin
            r_rs <= sn[W-1] ^ sd[W-1];
            r_u  <= mag(sn);
            r_v  <= mag(sd);
            r_qn <= mag(sn);
            r_qd <= mag(sd);
            r_k  <= '0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u >= r_v) begin
                r_u <= (r_u - r_v) >> 1;
            end else begin
                r_v <= (r_v - r_u) >> 1;
            end
        end
        if (i_cmd.div_start) begin
            r_g   <= g;
            r_cnt <= CW'(W);
            r_mn  <= '0;
            r_md  <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
            {r_mn, r_qn} <= dn;
            {r_md, r_qd} <= dd;
        end
        if (i_cmd.red_store) begin
            unique case (i_cmd.sel)
                RS_A: begin
                    r_an <= nn;
                    r_ad <= r_qd;
                end
                RS_B: begin
                    r_bn <= nn;
                    r_bd <= r_qd;
                end
                default: begin
                    r_rn <= nn;
                    r_rd <= r_qd;
                end
            endcase
        end
        if (i_cmd.mul_step) r_p[i_cmd.mul_idx] <= mul_x * mul_y;
        if (i_cmd.comb) begin
            r_rn <= rn_c;
            r_rd <= rd_c;
        end
        if (i_cmd.st_we) r_st <= i_cmd.st_code;
        if (i_cmd.out_we) begin
            r_ost  <= r_st;
            r_onum <= (r_st == ST_OK) ? r_rn : '0;
            r_oden <= (r_st == ST_OK) ? r_rd[W-2:0] : '0;
        end
    end

    assign o_stat.zero_den = (r_ad == '0) || (r_bd == '0);
    assign o_stat.div_zero = (r_mode == MODE_DIV) && (r_bn == '0);
    assign o_stat.gcd_done = (r_u == '0) || (r_v == '0);
    assign o_stat.div_done = (r_cnt == '0);
    assign o_stat.red_ovf  = (r_qd > MAXV) || (r_rs ? (r_qn > MINM) : (r_qn > MAXV));
    assign o_stat.comb_ovf = c_ovf;

    assign o_res_num = 32'(signed'(r_onum));
    assign o_res_den = 31'(r_oden);
    assign o_status  = r_ost;

endmodule

`default_nettype wire

[sv/rational_arithmetic_unit_top.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Reduced-fraction add, subtract, multiply and divide with status codes.
// ----------------------------------------------------------------------------
// One request on the slave channel carries the operation in tuser and four
// signed fractions fields in tdata; one result leaves on the master channel
// with the reduced fraction in tdata and the status code in tuser.
// Each request runs alone: both operands and then the result pass through
// one reduction unit (binary gcd, one step a cycle, then two restoring
// dividers in parallel), with four products on one shared multiplier in
// between. A request with a zero denominator skips reduction and goes
// straight to the output. The next request is taken once the previous
// result sits in the output register; if the receiver stalls, the result
// holds and the block stalls before writing the next one. Reset returns
// the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // a_num, a_den, b_num, b_den
    input  wire logic [127:0] s_axis_tdata,
    // mode
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // res_num, res_den, zero pad
    output logic [63:0]       m_axis_tdata,
    // status
    output logic [1:0]        m_axis_tuser
);

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic               r_m_valid;
    logic               out_free;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;

    assign out_free = !r_m_valid || m_axis_tready;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (out_free),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    rau_dp #(.W(WORD_BITS)) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_mode    (s_axis_tuser),
        .i_a_num   (s_axis_tdata[31:0]),
        .i_a_den   (s_axis_tdata[63:32]),
        .i_b_num   (s_axis_tdata[95:64]),
        .i_b_den   (s_axis_tdata[127:96]),
        .o_res_num (res_num),
        .o_res_den (res_den),
        .o_status  (m_axis_tuser)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (cmd.out_we) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, res_den, res_num};

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == 64'd0))
        else $error("error result not zero");

    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_OK) |-> (m_axis_tdata[62:32] != 31'd0))
        else $error("zero denominator on good result");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

endmodule

`default_nettype wire
